FILE: sv/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg
// Shared types and constants of the insertion sort buffer.
// ----------------------------------------------------------------------------
package isb_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input element as it waits in the front queue.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    // Head of the front queue as the sorter sees it.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // Status of the sorter, watched by the top level.
    typedef struct packed {
        logic draining;
        logic store_empty;
        logic over_capacity;
    } sort_status_t;

endpackage

FILE: sv/isb_front.sv
// ----------------------------------------------------------------------------
// isb_front
// Input side: a short queue that takes elements and tags each with its
// set-closing flag, so that input transfers go on while the sorter drains.
// ----------------------------------------------------------------------------
module isb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [isb_pkg::DATA_W-1:0] value,
    input  logic                             last,
    output isb_pkg::head_t                   head,
    input  logic                             q_pop
);
    import isb_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = q_pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= '{value: value, last: last};
        end
    end

endmodule

FILE: sv/isb_sorter.sv
// ----------------------------------------------------------------------------
// isb_sorter
// Back side: a row of compare-and-shift cells that inserts one element per
// cycle, then shifts the sorted set out through an output register.
// ----------------------------------------------------------------------------
module isb_sorter #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isb_pkg::head_t                    head,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [isb_pkg::DATA_W-1:0] sorted_value,
    output logic                              last_res,
    output logic                              overflow,
    output isb_pkg::sort_status_t             status
);
    import isb_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic signed [DATA_W-1:0] cell_reg  [DEPTH];
    logic signed [DATA_W-1:0] cell_next [DEPTH];
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_value_next;
    logic                     out_last_reg;
    logic                     out_last_next;
    logic                     out_ovf_reg;
    logic                     out_ovf_next;
    logic [DEPTH-1:0]         take;
    logic                     insert;
    logic                     drain_step;
    logic                     at_capacity;

    assign at_capacity = (count_reg == CNT_W'(DEPTH));
    assign insert      = (state_reg == ST_LOAD) && head.valid;
    assign q_pop       = insert;
    assign drain_step  = (state_reg == ST_DRAIN) && (!out_valid_reg || pop);

    // A cell takes a new entry when it is the first free place or holds a
    // value strictly greater than the incoming one; equal values keep order.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            take[i] = (count_reg == CNT_W'(i)) ||
                      ((CNT_W'(i) < count_reg) && (cell_reg[i] > head.item.value));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (insert)
                begin
                    if (!at_capacity)
                    begin
                        if (take[0])
                        begin
                            cell_next[0] = head.item.value;
                        end
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            if (take[i])
                            begin
                                cell_next[i] = take[i-1] ? cell_reg[i-1] : head.item.value;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (head.item.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_step)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cell_reg[0];
                    out_last_next  = (count_reg == CNT_W'(1));
                    out_ovf_next   = ovf_reg;
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        cell_next[i] = cell_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg      <= cell_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign empty        = !out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_res     = out_last_reg;
    assign overflow     = out_ovf_reg;

    assign status.draining      = (state_reg == ST_DRAIN);
    assign status.store_empty   = (count_reg == '0);
    assign status.over_capacity = (count_reg > CNT_W'(DEPTH));

endmodule

FILE: sv/insertion_sort_buffer_unit.sv
// ----------------------------------------------------------------------------
// insertion_sort_buffer_unit
// Streaming insertion sort: collects a set of signed values, then returns
// the set in ascending order with last and overflow marks.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------
//  input     push / full            value[31:0] signed, last
//  result    empty / pop            sorted_value[31:0] signed, last_res,
//                                   overflow
//
// Each element is inserted into the cell row once it reaches the head of
// the two-entry input queue, so loading runs at one element per cycle while
// the row is not draining. The element that closes a set starts a drain of
// the set, one result per cycle, paced by the output register and pop.
// While the row drains, new elements are held in the input queue, and full
// rises once that queue is full. Reset clears all control state at once;
// there is no clearing pass, since only stored entries are ever read.
//
module insertion_sort_buffer_unit #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [isb_pkg::DATA_W-1:0] value,
    input  logic                              last,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [isb_pkg::DATA_W-1:0] sorted_value,
    output logic                              last_res,
    output logic                              overflow
);
    import isb_pkg::*;

    head_t        head;
    logic         q_pop;
    sort_status_t status;

    // The front queue decouples input transfers from the sorter, so an
    // element can be taken while a result still waits to be popped.
    isb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .value (value),
        .last  (last),
        .head  (head),
        .q_pop (q_pop)
    );

    // The sorter inserts one element per cycle into its cell row and, once
    // a set closes, shifts the row out through its output register.
    isb_sorter #(
        .DEPTH (DEPTH)
    ) u_sorter (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .overflow     (overflow),
        .status       (status)
    );

    // The element count can never pass the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        !status.over_capacity)
    else $error("sorter holds more elements than it has cells");

    // No element leaves the queue while the row is draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.draining |-> !q_pop)
    else $error("queue popped during drain");

    // A draining row always still holds at least one element, since the
    // drain ends on the step that takes out the final one.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.draining |-> !status.store_empty)
    else $error("row is draining with no element left");

    // The overflow mark stays the same across the results of one set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_res) |=> (empty || $stable(overflow)))
    else $error("overflow mark changed within a set");

endmodule
